FILE: hdl/blzd_pkg.sv
`timescale 1ns / 1ps

package blzd_pkg;

    // Depth of the history window; must hold the largest distance (4098).
    localparam int WINDOW_DEPTH = 8192;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

    localparam int LEN_W  = 5;
    localparam int DIST_W = 13;
    localparam int CAP_W  = 32;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Command kinds passed from the parser to the output engine.
    localparam logic [1:0] CMD_LIT  = 2'd0;
    localparam logic [1:0] CMD_COPY = 2'd1;
    localparam logic [1:0] CMD_STAT = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_TRUNC = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_DIST  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;  // literal byte, or status code in the low bits
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_cmd;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] res;
        if (a == ADDR_W'(WINDOW_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = a + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: hdl/blzd_ram.sv
`timescale 1ns / 1ps

module blzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/blzd_front.sv
`timescale 1ns / 1ps

module blzd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [blzd_pkg::CAP_W-1:0]  i_capacity,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [7:0]                  i_tdata,
    input  logic                        i_tlast,
    input  logic                        i_q_full,
    output logic                        o_push,
    output blzd_pkg::t_cmd              o_cmd
);

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_REF2  = 2'd2;

    logic [1:0]                       r_phase, n_phase;
    logic [7:0]                       r_flags, n_flags;
    logic [2:0]                       r_bit, n_bit;
    logic [7:0]                       r_first, n_first;
    logic [blzd_pkg::CAP_W-1:0]       r_produced, n_produced;
    logic                             r_failed, n_failed;

    logic                             acc;
    logic                             clear;
    logic [blzd_pkg::LEN_W-1:0]       ref_len;
    logic [blzd_pkg::DIST_W-1:0]      ref_dist;
    logic [blzd_pkg::CAP_W-1:0]       room;

    assign o_tready = !i_q_full;
    assign acc      = i_tvalid && o_tready;
    assign ref_len  = blzd_pkg::LEN_W'(3) + {1'b0, r_first[7:4]};
    assign ref_dist = blzd_pkg::DIST_W'(3) + {1'b0, r_first[3:0], i_tdata};
    assign room     = i_capacity - r_produced;

    always_comb begin
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_bit      = r_bit;
        n_first    = r_first;
        n_produced = r_produced;
        n_failed   = r_failed;
        clear      = 1'b0;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.last = i_tlast;

        if (acc) begin
            if (r_failed) begin
                clear = i_tlast;
            end else begin
                unique case (r_phase)
                    PH_FLAG: begin
                        if (i_tlast) begin
                            o_push       = 1'b1;
                            o_cmd.kind   = blzd_pkg::CMD_STAT;
                            o_cmd.data   = {6'd0, blzd_pkg::STAT_OK};
                            clear        = 1'b1;
                        end else begin
                            n_flags = i_tdata;
                            n_bit   = '0;
                            n_phase = PH_TOKEN;
                        end
                    end
                    PH_TOKEN: begin
                        if (r_flags[3'd7 - r_bit]) begin
                            if (i_tlast) begin
                                o_push     = 1'b1;
                                o_cmd.kind = blzd_pkg::CMD_STAT;
                                o_cmd.data = {6'd0, blzd_pkg::STAT_TRUNC};
                                clear      = 1'b1;
                            end else begin
                                n_first = i_tdata;
                                n_phase = PH_REF2;
                            end
                        end else if (r_produced >= i_capacity) begin
                            o_push     = 1'b1;
                            o_cmd.kind = blzd_pkg::CMD_STAT;
                            o_cmd.data = {6'd0, blzd_pkg::STAT_FULL};
                            o_cmd.last = 1'b1;
                            clear      = i_tlast;
                            n_failed   = !i_tlast;
                        end else begin
                            o_push     = 1'b1;
                            o_cmd.kind = blzd_pkg::CMD_LIT;
                            o_cmd.data = i_tdata;
                            n_produced = r_produced + blzd_pkg::CAP_W'(1);
                            n_bit      = r_bit + 3'd1;
                            n_phase    = (n_bit == 3'd0) ? PH_FLAG : PH_TOKEN;
                            clear      = i_tlast;
                        end
                    end
                    default: begin
                        // Second reference byte; the unused phase code lands here too.
                        o_push = 1'b1;
                        if (room < blzd_pkg::CAP_W'(ref_len)) begin
                            o_cmd.kind = blzd_pkg::CMD_STAT;
                            o_cmd.data = {6'd0, blzd_pkg::STAT_FULL};
                            o_cmd.last = 1'b1;
                            clear      = i_tlast;
                            n_failed   = !i_tlast;
                        end else if (blzd_pkg::CAP_W'(ref_dist) > r_produced) begin
                            o_cmd.kind = blzd_pkg::CMD_STAT;
                            o_cmd.data = {6'd0, blzd_pkg::STAT_DIST};
                            o_cmd.last = 1'b1;
                            clear      = i_tlast;
                            n_failed   = !i_tlast;
                        end else begin
                            o_cmd.kind     = blzd_pkg::CMD_COPY;
                            o_cmd.len      = ref_len;
                            o_cmd.distance = ref_dist;
                            n_produced     = r_produced + blzd_pkg::CAP_W'(ref_len);
                            n_bit          = r_bit + 3'd1;
                            n_phase        = (n_bit == 3'd0) ? PH_FLAG : PH_TOKEN;
                            clear          = i_tlast;
                        end
                    end
                endcase
            end

            if (clear) begin
                n_phase    = PH_FLAG;
                n_flags    = '0;
                n_bit      = '0;
                n_first    = '0;
                n_produced = '0;
                n_failed   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_flags    <= '0;
            r_bit      <= '0;
            r_first    <= '0;
            r_produced <= '0;
            r_failed   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_bit      <= n_bit;
            r_first    <= n_first;
            r_produced <= n_produced;
            r_failed   <= n_failed;
        end
    end

endmodule

FILE: hdl/blzd_cmd_fifo.sv
`timescale 1ns / 1ps

module blzd_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blzd_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output blzd_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    blzd_pkg::t_cmd                r_mem [blzd_pkg::CMDQ_DEPTH];
    logic [blzd_pkg::CMDQ_AW-1:0]  r_wr, r_rd;
    logic [blzd_pkg::CMDQ_AW:0]    r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (blzd_pkg::CMDQ_AW + 1)'(blzd_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + blzd_pkg::CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + blzd_pkg::CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (blzd_pkg::CMDQ_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (blzd_pkg::CMDQ_AW + 1)'(1);
            end
        end
    end

endmodule

FILE: hdl/blzd_back.sv
`timescale 1ns / 1ps

module blzd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  blzd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_tdata,
    output logic [2:0]     o_tuser,
    output logic           o_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COPY = 1'b1;

    localparam int AW = blzd_pkg::ADDR_W;

    logic                        r_state, n_state;
    logic [AW-1:0]               r_wptr, n_wptr;
    logic [AW-1:0]               r_rptr, n_rptr;
    logic [blzd_pkg::LEN_W-1:0]  r_remain, n_remain;
    logic                        r_copy_last, n_copy_last;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_out_bv;
    logic [1:0]                  r_out_status;
    logic                        r_out_last;

    logic                        slot_free;
    logic                        load;
    logic [7:0]                  ld_byte;
    logic                        ld_bv;
    logic [1:0]                  ld_status;
    logic                        ld_last;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               rd_addr;
    logic [7:0]                  wr_data, rd_data;
    logic [AW:0]                 w_ext, d_ext;
    logic [AW-1:0]               start;

    assign slot_free = !r_out_valid || i_tready;

    // Start of a copy, wrapped back into the window.
    assign w_ext = {1'b0, r_wptr};
    assign d_ext = (AW + 1)'(i_cmd.distance);
    always_comb begin
        if (w_ext >= d_ext) begin
            start = AW'(w_ext - d_ext);
        end else begin
            start = AW'(w_ext + (AW + 1)'(blzd_pkg::WINDOW_DEPTH) - d_ext);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_remain    = r_remain;
        n_copy_last = r_copy_last;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_rptr;
        load        = 1'b0;
        ld_byte     = '0;
        ld_bv       = 1'b0;
        ld_status   = blzd_pkg::STAT_OK;
        ld_last     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    priority if (i_cmd.kind == blzd_pkg::CMD_COPY) begin
                        o_pop       = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = start;
                        n_rptr      = blzd_pkg::ptr_inc(start);
                        n_remain    = i_cmd.len;
                        n_copy_last = i_cmd.last;
                        n_state     = ST_COPY;
                    end else if (i_cmd.kind == blzd_pkg::CMD_LIT && slot_free) begin
                        o_pop   = 1'b1;
                        wr_en   = 1'b1;
                        wr_data = i_cmd.data;
                        load    = 1'b1;
                        ld_byte = i_cmd.data;
                        ld_bv   = 1'b1;
                        ld_last = i_cmd.last;
                        n_wptr  = i_cmd.last ? '0 : blzd_pkg::ptr_inc(r_wptr);
                    end else if (i_cmd.kind != blzd_pkg::CMD_LIT && slot_free) begin
                        o_pop     = 1'b1;
                        load      = 1'b1;
                        ld_status = i_cmd.data[1:0];
                        ld_last   = i_cmd.last;
                        if (i_cmd.last) begin
                            n_wptr = '0;
                        end
                    end else begin
                        o_pop = 1'b0;
                    end
                end
            end
            ST_COPY: begin
                if (slot_free) begin
                    // The next source byte lies at least two places behind the write,
                    // so the read may overlap the write of this byte.
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    load     = 1'b1;
                    ld_byte  = rd_data;
                    ld_bv    = 1'b1;
                    ld_last  = (r_remain == blzd_pkg::LEN_W'(1)) && r_copy_last;
                    n_wptr   = ld_last ? '0 : blzd_pkg::ptr_inc(r_wptr);
                    n_remain = r_remain - blzd_pkg::LEN_W'(1);
                    if (r_remain == blzd_pkg::LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en  = 1'b1;
                        n_rptr = blzd_pkg::ptr_inc(r_rptr);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    blzd_ram #(
        .WIDTH (8),
        .DEPTH (blzd_pkg::WINDOW_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_remain    <= '0;
            r_copy_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_remain    <= n_remain;
            r_copy_last <= n_copy_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= ld_byte;
            r_out_bv     <= ld_bv;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tuser  = {r_out_status, r_out_bv};
    assign o_tlast  = r_out_last;

endmodule

FILE: hdl/backward_lz_decompressor_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Word content
// -------   ---------  ------------------------------------------------
// i_s_*     in         tdata: compressed byte, tlast: last byte of stream
// o_m_*     out        tdata: output byte, tuser: valid flag + status, tlast
// cfg       in         i_cfg_data: output capacity in bytes
//
// The output engine loads a literal straight into the output register; a
// reference first starts the history read, then copies its bytes one by one.
// Flag bytes and first reference bytes produce no output.
// The parser keeps accepting while the four-entry command queue has room.
// Reset is synchronous and active low; the history needs no clearing pass.

module backward_lz_decompressor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [2:0]  o_m_tuser,   // [0] byte_valid, [2:1] status
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [blzd_pkg::CAP_W-1:0] r_capacity;
    logic                       q_full, q_push, q_valid, q_pop;
    blzd_pkg::t_cmd             push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    blzd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_tvalid   (i_s_tvalid),
        .o_tready   (o_s_tready),
        .i_tdata    (i_s_tdata),
        .i_tlast    (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    blzd_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    blzd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tuser     (o_m_tuser),
        .o_tlast     (o_m_tlast)
    );

endmodule

FILE: hdl/blzd_checker.sv
`timescale 1ns / 1ps

module blzd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled output word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // A status-only word always closes the stream.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast)
        else $error("status word without last");

    // Data words always report success.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tuser[2:1] == blzd_pkg::STAT_OK)
        else $error("data word with nonzero status");

    // Nothing is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind backward_lz_decompressor_unit blzd_checker u_blzd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_m_tlast   (o_m_tlast)
);

FILE: dv/backward_lz_decompressor_unit_tb.sv
`timescale 1ns / 1ps

module backward_lz_decompressor_unit_tb;

    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SEG_ITEMS     = 60;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_REF2  = 2'd2
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] status;
        logic       last;
    } t_dec_word;

    typedef struct packed {
        logic        is_cfg;
        logic [31:0] cap;
        logic [7:0]  data;
        logic        last;
        logic        typed;
        t_dec_word   want;
    } t_stim_row;

    localparam t_dec_word NO_WORD = '0;

    // Directed opening: capacity zero after reset, end on a flag byte, literal extremes,
    // shortest and longest copies, a distance too far back, a truncated reference,
    // and an overflow that must win over a bad distance.
    localparam t_stim_row DIRECTED [26] = '{
        '{1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'hAB, 1'b0, 1'b1, '{8'h00, 1'b0, blzd_pkg::STAT_FULL, 1'b1}},
        '{1'b0, 32'd0, 8'h55, 1'b1, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'hC3, 1'b1, 1'b1, '{8'h00, 1'b0, blzd_pkg::STAT_OK, 1'b1}},
        '{1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h1F, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, blzd_pkg::STAT_OK, 1'b0}},
        '{1'b0, 32'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, blzd_pkg::STAT_OK, 1'b0}},
        '{1'b0, 32'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, blzd_pkg::STAT_OK, 1'b0}},
        '{1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'hF0, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h0F, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, blzd_pkg::STAT_DIST, 1'b1}},
        '{1'b0, 32'd0, 8'h12, 1'b1, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h80, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h33, 1'b1, 1'b1, '{8'h00, 1'b0, blzd_pkg::STAT_TRUNC, 1'b1}},
        '{1'b1, 32'd5, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h08, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h11, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h22, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h33, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h44, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'h0F, 1'b0, 1'b0, NO_WORD},
        '{1'b0, 32'd0, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, blzd_pkg::STAT_FULL, 1'b1}}
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;   // [7:0] in_byte
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;          // [7:0] out_byte
    logic [2:0]  o_m_tuser;          // [0] byte_valid, [2:1] status
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;

    backward_lz_decompressor_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Decoder state mirrored by the testbench.
    t_dec_phase  phase;
    logic [7:0]  flags;
    logic [2:0]  bit_idx;
    logic [7:0]  ref_hi;
    logic [31:0] produced;
    logic        strm_failed;
    logic [31:0] capacity;
    logic [7:0]  hist [blzd_pkg::WINDOW_DEPTH];

    t_dec_word   step_words[$];
    t_dec_word   pending_words[$];

    int tx_idle = 0;
    int rx_idle = 0;
    int seg_items;
    int errors = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void restart_stream();
        phase       = PH_FLAG;
        flags       = '0;
        bit_idx     = '0;
        ref_hi      = '0;
        produced    = '0;
        strm_failed = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] d, input logic vld,
                                 input logic [1:0] st, input logic l);
        t_dec_word w;
        w = '{d, vld, st, l};
        step_words.push_back(w);
    endfunction

    // An error word always closes the stream; if more input follows, it is swallowed.
    function automatic void raise_error(input logic [1:0] code, input logic l);
        emit(8'h00, 1'b0, code, 1'b1);
        if (l) begin
            restart_stream();
        end else begin
            strm_failed = 1'b1;
        end
    endfunction

    function automatic void store(input logic [7:0] b);
        hist[produced % blzd_pkg::WINDOW_DEPTH] = b;
        produced = produced + 1;
    endfunction

    function automatic void advance();
        bit_idx = bit_idx + 3'd1;
        phase   = (bit_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic l);
        logic [31:0] run_len;
        logic [31:0] copy_dist;
        logic [7:0]  v;
        step_words.delete();
        if (strm_failed) begin
            if (l) begin
                restart_stream();
            end
            return;
        end
        case (phase)
            PH_FLAG: begin
                if (l) begin
                    emit(8'h00, 1'b0, blzd_pkg::STAT_OK, 1'b1);
                    restart_stream();
                end else begin
                    flags   = b;
                    bit_idx = '0;
                    phase   = PH_TOKEN;
                end
            end
            PH_TOKEN: begin
                if (flags[3'd7 - bit_idx]) begin
                    if (l) begin
                        raise_error(blzd_pkg::STAT_TRUNC, 1'b1);
                    end else begin
                        ref_hi = b;
                        phase  = PH_REF2;
                    end
                end else if (produced >= capacity) begin
                    raise_error(blzd_pkg::STAT_FULL, l);
                end else begin
                    store(b);
                    emit(b, 1'b1, blzd_pkg::STAT_OK, l);
                    advance();
                    if (l) begin
                        restart_stream();
                    end
                end
            end
            default: begin
                run_len   = 32'd3 + 32'(ref_hi[7:4]);
                copy_dist = 32'd3 + 32'({ref_hi[3:0], b});
                if (capacity - produced < run_len) begin
                    raise_error(blzd_pkg::STAT_FULL, l);
                end else if (copy_dist > produced) begin
                    raise_error(blzd_pkg::STAT_DIST, l);
                end else begin
                    for (int i = 0; i < int'(run_len); i++) begin
                        v = hist[(produced - copy_dist) % blzd_pkg::WINDOW_DEPTH];
                        store(v);
                        emit(v, 1'b1, blzd_pkg::STAT_OK,
                             (i == int'(run_len) - 1) ? l : 1'b0);
                    end
                    advance();
                    if (l) begin
                        restart_stream();
                    end
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_dec_word want);
        while ($urandom_range(99) < tx_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, l);
        seg_items++;
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            foreach (step_words[k]) begin
                pending_words.push_back(step_words[k]);
            end
        end
    endtask

    task automatic set_capacity(input logic [31:0] cap);
        i_s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        // Flag bytes and swallowed bytes leave no word behind, so give the block time.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity = cap;
    endtask

    // One compressed stream: mostly well formed with legal distances, some with
    // arbitrary distances or a cut-off reference, some plain noise.
    task automatic run_stream();
        logic [7:0]  sq[$];
        logic [11:0] off;
        logic [3:0]  nib;
        int          pick;
        int          n_tok;
        int          flag_at;
        int          made;
        int          dist_max;
        bit          broken;
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(12, 1)) sq.push_back(8'($urandom_range(255)));
        end else begin
            broken  = (pick < 27);
            n_tok   = $urandom_range(24, 1);
            made    = 0;
            flag_at = 0;
            for (int t = 0; t < n_tok; t++) begin
                if (t % 8 == 0) begin
                    flag_at = sq.size();
                    sq.push_back(8'h00);
                end
                if ((made >= 3 || broken) && $urandom_range(1) == 1) begin
                    sq[flag_at] = sq[flag_at] | (8'h80 >> (t % 8));
                    nib = 4'($urandom_range(15));
                    if (broken) begin
                        off = 12'($urandom_range(4095));
                    end else begin
                        dist_max = (made > 4098) ? 4098 : made;
                        off = 12'($urandom_range(dist_max - 3));
                    end
                    sq.push_back({nib, off[11:8]});
                    if (broken && t == n_tok - 1 && $urandom_range(1) == 1) begin
                        break;
                    end
                    sq.push_back(off[7:0]);
                    made += 3 + nib;
                end else begin
                    sq.push_back(8'($urandom_range(255)));
                    made++;
                end
            end
            // With all flag bits used up, the stream may also end on a flag position.
            if (n_tok % 8 == 0 && $urandom_range(1) == 1) begin
                sq.push_back(8'($urandom_range(255)));
            end
        end
        foreach (sq[i]) begin
            send_byte(sq[i], i == sq.size() - 1, 1'b0, NO_WORD);
        end
    endtask

    // Result side: ready pattern plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_dec_word got;
        t_dec_word want;
        bit        bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata, o_m_tuser[0], o_m_tuser[2:1], o_m_tlast};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                errors++;
            end else begin
                want = pending_words.pop_front();
                bad  = 1'b0;
                if (got.data !== want.data) begin
                    $display("%0t: out_byte expected %h got %h", $time, want.data, got.data);
                    bad = 1'b1;
                end
                if (got.valid !== want.valid) begin
                    $display("%0t: byte_valid expected %b got %b", $time, want.valid, got.valid);
                    bad = 1'b1;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             got.status);
                    bad = 1'b1;
                end
                if (got.last !== want.last) begin
                    $display("%0t: tlast expected %b got %b", $time, want.last, got.last);
                    bad = 1'b1;
                end
                if (bad) begin
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("backward_lz_decompressor_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] cap;
        capacity = '0;
        restart_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 17;
        rx_idle = 51;
        for (int r = 0; r < $size(DIRECTED); r++) begin
            if (DIRECTED[r].is_cfg) begin
                set_capacity(DIRECTED[r].cap);
            end else begin
                send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed,
                          DIRECTED[r].want);
            end
        end

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       cap = $urandom_range(64, 8);
                1, 4:    cap = 32'hFFFF_FFFF;
                2:       cap = 32'd0;
                3:       cap = $urandom_range(3000, 200);
                default: cap = $urandom_range(16, 1);
            endcase
            set_capacity(cap);
            tx_idle = (seg < 2) ? 17 : (seg < 4) ? 51 : 0;
            rx_idle = (seg < 2) ? 51 : (seg < 4) ? 17 : 0;
            if (seg == 4) begin
                hold_req = 1'b1;
            end
            seg_items = 0;
            while (seg_items < SEG_ITEMS) begin
                run_stream();
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("backward_lz_decompressor_unit: match");
        end else begin
            $display("backward_lz_decompressor_unit: mismatch");
        end
        $finish;
    end

endmodule
